### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk and disabled while
// the synchronous reset i_rst_n is held low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside of reset.
`define STBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// The expression must never be true at a rising clock edge outside of reset.
`define STBC_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

### src/stbc_pkg.sv
// ----------------------------------------------------------------------------
// Splitter tree bucket classifier package
// Beat control type shared by the pipeline modules, and the function codes and key port width of the top.
// ----------------------------------------------------------------------------
package stbc_pkg;

    // Function codes of an input beat.
    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // Width of the key port, fixed by the interface.
    localparam int KEY_PORT_BITS = 64;

    // Control that travels with every beat down the pipeline.
    typedef struct packed {
        logic valid;
        logic classify;
    } t_ctl;

endpackage

### src/stbc_level.sv
// ----------------------------------------------------------------------------
// Splitter tree level stage
// Holds the tree nodes of one level, reads the node of the beat's path and
// steps a classify beat's path left or right; load beats aimed at this level write it.
// ----------------------------------------------------------------------------
module stbc_level #(
    parameter int LEVELS   = 10,
    parameter int KEY_BITS = 64,
    parameter int LVL      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stbc_pkg::t_ctl        i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [LEVELS:0]       i_path,
    input  logic [LEVELS-1:0]     i_pos,
    output stbc_pkg::t_ctl        o_ctl,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [LEVELS:0]       o_path,
    output logic [LEVELS-1:0]     o_pos
);

    localparam int PW    = LEVELS + 1;
    localparam int AW    = (LVL > 0) ? LVL : 1;
    localparam int DEPTH = 1 << AW;

    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_node;
    stbc_pkg::t_ctl      r_ctl;
    logic [KEY_BITS-1:0] r_key;
    logic [PW-1:0]       r_path;
    logic [LEVELS-1:0]   r_pos;

    logic [AW-1:0] w_addr;
    logic          w_we;

    // The path is the heap index: its leading one marks the level it belongs to.
    assign w_addr = i_path[AW-1:0];
    assign w_we   = i_ctl.valid && !i_ctl.classify && ((i_path >> LVL) == PW'(1));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= i_key;
        end
        r_node <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_path <= i_path;
        r_pos  <= i_pos;
    end

    // Go right when the key is above the node.
    assign o_path = r_ctl.classify ? {r_path[PW-2:0], (r_key > r_node)} : r_path;
    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_pos  = r_pos;

endmodule

### src/stbc_leaf.sv
// ----------------------------------------------------------------------------
// Splitter tree leaf stage
// Holds the sorted splitters, checks the reached leaf's splitter for an
// equal key and registers the bucket result.
// ----------------------------------------------------------------------------
module stbc_leaf #(
    parameter int LEVELS   = 10,
    parameter int KEY_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stbc_pkg::t_ctl        i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [LEVELS:0]       i_path,
    input  logic [LEVELS-1:0]     i_pos,
    output logic                  o_strobe,
    output logic [LEVELS:0]       o_bucket
);

    localparam int NUM_SPLIT = (1 << LEVELS) - 1;

    logic [KEY_BITS-1:0] r_mem [NUM_SPLIT];
    logic [KEY_BITS-1:0] r_split;
    stbc_pkg::t_ctl      r_ctl;
    logic [KEY_BITS-1:0] r_key;
    logic [LEVELS-1:0]   r_leaf;
    logic                r_top;
    logic                r_strobe;
    logic [LEVELS:0]     r_bucket;

    logic [LEVELS-1:0] w_leaf;
    logic              w_top;
    logic              w_load;
    logic              w_eq;

    assign w_leaf = i_path[LEVELS-1:0];
    // The rightmost leaf has no splitter of its own.
    assign w_top  = (w_leaf == {LEVELS{1'b1}});
    assign w_load = i_ctl.valid && !i_ctl.classify;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[i_pos] <= i_key;
        end else if (!w_top) begin
            r_split <= r_mem[w_leaf];
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_leaf <= w_leaf;
        r_top  <= w_top;
    end

    assign w_eq = !r_top && (r_split == r_key);

    always_ff @(posedge i_clk) begin
        r_bucket <= {r_leaf, w_eq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_ctl    <= i_ctl;
            r_strobe <= r_ctl.valid && r_ctl.classify;
        end
    end

    assign o_strobe = r_strobe;
    assign o_bucket = r_bucket;

endmodule

### src/splitter_tree_bucket_classifier_top.sv
// ----------------------------------------------------------------------------
// Splitter tree bucket classifier
// Sample-sort classifier: load beats fill a splitter tree, classify beats
// descend it one level per pipeline stage and return a bucket id.
// ----------------------------------------------------------------------------
// Usage. A beat is accepted at a rising edge where start is high and busy is
// low. With i_func = load, i_key is stored as the splitter at sorted place
// i_position and mirrored into its heap node of the tree; a load to the
// all-ones position is dropped. With i_func = classify, i_key is looked up
// and exactly one result beat follows on o_bucket, marked by o_strobe for
// one cycle: 2i for leaf i, or 2i+1 when splitter i equals the key.
// Throughput is one beat per cycle, loads and classifies mixed freely; busy
// is low except while reset is held. On its way to the strobe, a classify
// beat passes the entry stage, one registered memory read per tree level,
// the splitter read and the output register. Every load travels the same
// pipeline and writes each memory at the stage where classifies read it,
// so results always see the loads that came before them and never the
// later ones. Reset is synchronous; it empties the pipeline but leaves the
// splitter memories as they were. The receiver cannot stall; results are
// not held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module splitter_tree_bucket_classifier_top #(
    parameter int TREE_LEVELS = 10,
    parameter int KEY_BITS    = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [TREE_LEVELS-1:0]              i_position,
    input  logic [stbc_pkg::KEY_PORT_BITS-1:0]  i_key,
    output logic                                o_strobe,
    output logic [TREE_LEVELS:0]                o_bucket
);

    localparam int PW  = TREE_LEVELS + 1;
    // Edges from an accepted classify to the edge that takes its result.
    localparam int LAT = TREE_LEVELS + 3;

    // Per-stage beat signals; index 0 is the entry register.
    stbc_pkg::t_ctl         w_ctl  [TREE_LEVELS+1];
    logic [KEY_BITS-1:0]    w_key  [TREE_LEVELS+1];
    logic [PW-1:0]          w_path [TREE_LEVELS+1];
    logic [TREE_LEVELS-1:0] w_pos  [TREE_LEVELS+1];

    stbc_pkg::t_ctl         r_ctl0;
    logic [KEY_BITS-1:0]    r_key0;
    logic [PW-1:0]          r_path0;
    logic [TREE_LEVELS-1:0] r_pos0;

    stbc_pkg::t_ctl         n_ctl0;
    logic [PW-1:0]          n_path0;

    logic                   w_acc;
    logic                   w_acc_cls;
    logic [TREE_LEVELS-1:0] w_q;
    logic [TREE_LEVELS-1:0] w_oh;
    logic [PW-1:0]          w_node;

    assign busy      = !i_rst_n;
    assign w_acc     = start && !busy;
    assign w_acc_cls = w_acc && (i_func == stbc_pkg::FUNC_CLASSIFY);

    // Heap node of a sorted position: with q = position + 1 and h its lowest
    // set bit, the node is 2^(levels-1-h) + (q >> (h+1)). Its leading one
    // tells the level, the bits below it the place within that level.
    assign w_q  = i_position + TREE_LEVELS'(1);
    assign w_oh = w_q & (~w_q + TREE_LEVELS'(1));

    always_comb begin
        w_node = '0;
        for (int b = 0; b < TREE_LEVELS; b++) begin
            if (w_oh[b]) begin
                w_node = w_node | (PW'(1) << (TREE_LEVELS - 1 - b)) | (PW'(w_q) >> (b + 1));
            end
        end
    end

    // A classify starts at the root, heap index one. An out-of-range load
    // enters as an empty slot.
    always_comb begin
        n_ctl0.classify = (i_func == stbc_pkg::FUNC_CLASSIFY);
        n_ctl0.valid    = w_acc && (n_ctl0.classify || (i_position != {TREE_LEVELS{1'b1}}));
        n_path0         = n_ctl0.classify ? PW'(1) : w_node;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key0  <= i_key[KEY_BITS-1:0];
        r_path0 <= n_path0;
        r_pos0  <= i_position;
    end

    assign w_ctl[0]  = r_ctl0;
    assign w_key[0]  = r_key0;
    assign w_path[0] = r_path0;
    assign w_pos[0]  = r_pos0;

    for (genvar g = 0; g < TREE_LEVELS; g++) begin : g_level
        stbc_level #(
            .LEVELS   (TREE_LEVELS),
            .KEY_BITS (KEY_BITS),
            .LVL      (g)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_key   (w_key[g]),
            .i_path  (w_path[g]),
            .i_pos   (w_pos[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_key   (w_key[g+1]),
            .o_path  (w_path[g+1]),
            .o_pos   (w_pos[g+1])
        );
    end

    stbc_leaf #(
        .LEVELS   (TREE_LEVELS),
        .KEY_BITS (KEY_BITS)
    ) u_leaf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl[TREE_LEVELS]),
        .i_key    (w_key[TREE_LEVELS]),
        .i_path   (w_path[TREE_LEVELS]),
        .i_pos    (w_pos[TREE_LEVELS]),
        .o_strobe (o_strobe),
        .o_bucket (o_bucket)
    );

    // Every result comes from a classify beat accepted a fixed time earlier.
    `STBC_ASSERT(a_strobe_source, o_strobe |-> $past(w_acc_cls, LAT), "result without classify")
    // Every classify beat gets its result after the fixed latency.
    `STBC_ASSERT(a_classify_result, w_acc_cls |-> ##LAT o_strobe, "classify result missing")
    // The rightmost leaf has no splitter, so it never gives an equal bucket.
    `STBC_NEVER(a_no_equal_top, o_strobe && (&o_bucket), "equal bucket on top leaf")

endmodule
